// ===== design/dhte_pkg.sv =====
// ----------------------------------------------------------------------------
// dhte_pkg
// Shared types and codes for the double-hashing table engine: controller
// states, the command and status groups between controller and datapath,
// and the operation codes.
// ----------------------------------------------------------------------------
package dhte_pkg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE
    } state_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic clear;   // sweep one key slot to empty
        logic load;    // capture a new item
        logic probe;   // check one slot of the probe path
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_last;  // sweep is at the last slot
        logic probe_done;  // current item ends this cycle
    } ctl_status_t;

endpackage

// ===== design/dhte_ctrl.sv =====
// ----------------------------------------------------------------------------
// dhte_ctrl
// Controller of the table engine: runs the key-store sweep after reset,
// takes items while idle and steps the datapath through the probe path.
// ----------------------------------------------------------------------------
module dhte_ctrl
    import dhte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  ctl_status_t status,
    output ctl_cmd_t    cmd,
    output logic        busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (status.probe_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_PROBE:
            begin
                cmd.probe = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== design/dhte_datapath.sv =====
// ----------------------------------------------------------------------------
// dhte_datapath
// Key and payload memories, probe address stepping, slot compare, counters,
// the slot_bits register and the result registers.
// ----------------------------------------------------------------------------
module dhte_datapath
    import dhte_pkg::*;
#(
    parameter int ADDR_BITS = 10,
    parameter int KEY_BITS  = 32,
    parameter int DATA_BITS = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  ctl_cmd_t     cmd,
    output ctl_status_t  status,
    input  logic         cfg_we,
    input  logic [3:0]   cfg_data,
    input  logic         operation,
    input  logic [31:0]  key_first,
    input  logic [31:0]  key_step,
    input  logic [63:0]  data_word,
    output logic         done,
    output logic         found,
    output logic [9:0]   slot_index,
    output logic [63:0]  data_out,
    output logic         probe_error,
    output logic [10:0]  entry_count,
    output logic [31:0]  collision_count
);

    localparam int SLOTS   = 1 << ADDR_BITS;
    localparam int CNT_W   = ADDR_BITS + 1;
    localparam int KEY_W   = 2 * KEY_BITS;
    localparam int SB_RST  = (ADDR_BITS < 10) ? ADDR_BITS : 10;
    localparam logic [31:0] KEY_MASK = 32'hFFFF_FFFF >> (32 - KEY_BITS);

    logic [KEY_W-1:0]     key_mem [SLOTS];
    logic [DATA_BITS-1:0] pay_mem [SLOTS];

    logic [3:0]           slot_bits_reg;
    logic [3:0]           slot_bits_next;
    logic [ADDR_BITS-1:0] clr_cnt_reg;
    logic [CNT_W-1:0]     entries_reg;
    logic [31:0]          collisions_reg;
    logic                 done_reg;

    logic                 op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [DATA_BITS-1:0] data_reg;
    logic [ADDR_BITS-1:0] step_reg;
    logic [ADDR_BITS-1:0] raw_reg;
    logic [CNT_W-1:0]     probe_cnt_reg;
    logic [KEY_W-1:0]     rd_key_reg;
    logic [DATA_BITS-1:0] rd_pay_reg;

    logic                 found_reg;
    logic [9:0]           slot_reg;
    logic [63:0]          dout_reg;
    logic                 err_reg;

    logic [31:0]          first_m;
    logic [31:0]          step_m;
    logic [KEY_W-1:0]     key_in;
    logic [CNT_W-1:0]     limit;
    logic [CNT_W-1:0]     mask_full;
    logic [ADDR_BITS-1:0] mask;
    logic [ADDR_BITS-1:0] home_addr;
    logic [ADDR_BITS-1:0] raw_next;
    logic [ADDR_BITS-1:0] cur_addr;
    logic [ADDR_BITS-1:0] rd_addr;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [KEY_W-1:0]     wr_key;
    logic                 key_we;
    logic [CNT_W-1:0]     cnt_inc;
    logic                 at_limit;
    logic                 key_zero;
    logic                 slot_empty;
    logic                 slot_match;
    logic                 probe_done;
    logic                 res_found;
    logic                 res_err;
    logic [DATA_BITS-1:0] res_data;
    logic                 ins_write;
    logic                 coll_inc;

    // input masking and key assembly
    assign first_m   = key_first & KEY_MASK;
    assign step_m    = key_step & KEY_MASK;
    assign key_in    = {first_m[KEY_BITS-1:0], step_m[KEY_BITS-1:0]};

    assign limit     = CNT_W'(1) << slot_bits_reg;
    assign mask_full = limit - CNT_W'(1);
    assign mask      = mask_full[ADDR_BITS-1:0];
    assign home_addr = first_m[ADDR_BITS-1:0] & mask;

    // raw_reg holds first + i*step (low bits); the probe slot is it masked
    assign raw_next  = raw_reg + step_reg;
    assign cur_addr  = raw_reg & mask;
    // idle: home slot of the item on the ports; probing: next slot on the path
    assign rd_addr   = cmd.probe ? (raw_next & mask) : home_addr;

    assign cnt_inc    = probe_cnt_reg + CNT_W'(1);
    assign at_limit   = (cnt_inc == limit);
    assign key_zero   = (key_reg == '0);
    assign slot_empty = (rd_key_reg == '0);
    assign slot_match = (rd_key_reg == key_reg);

    always_comb
    begin
        probe_done = 1'b0;
        res_found  = 1'b0;
        res_err    = 1'b0;
        res_data   = '0;
        ins_write  = 1'b0;
        coll_inc   = 1'b0;
        if (cmd.probe)
        begin
            if (op_reg == OP_INSERT)
            begin
                if (key_zero)
                begin
                    probe_done = 1'b1;
                end
                else
                begin
                    if ((probe_cnt_reg == '0) && !slot_empty && (collisions_reg != '1))
                    begin
                        coll_inc = 1'b1;
                    end
                    if (slot_empty)
                    begin
                        ins_write  = 1'b1;
                        probe_done = 1'b1;
                        res_found  = 1'b1;
                        res_data   = data_reg;
                    end
                    else if (at_limit)
                    begin
                        probe_done = 1'b1;
                        res_err    = 1'b1;
                    end
                end
            end
            else
            begin
                if (slot_empty)
                begin
                    probe_done = 1'b1;
                end
                else if (slot_match)
                begin
                    probe_done = 1'b1;
                    res_found  = 1'b1;
                    res_data   = rd_pay_reg;
                end
                else if (at_limit)
                begin
                    probe_done = 1'b1;
                    res_err    = 1'b1;
                end
            end
        end
    end

    assign status.clear_last = (clr_cnt_reg == '1);
    assign status.probe_done = probe_done;

    // memory write side: sweep after reset, or an insert into an empty slot
    assign key_we  = cmd.clear | ins_write;
    assign wr_addr = cmd.clear ? clr_cnt_reg : cur_addr;
    assign wr_key  = cmd.clear ? '0 : key_reg;

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        rd_key_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ins_write)
        begin
            pay_mem[cur_addr] <= data_reg;
        end
        rd_pay_reg <= pay_mem[rd_addr];
    end

    // slot_bits write clamps zero to one and large values to ADDR_BITS
    always_comb
    begin
        slot_bits_next = cfg_data;
        if (cfg_data == 4'd0)
        begin
            slot_bits_next = 4'd1;
        end
        else if ({1'b0, cfg_data} > 5'(ADDR_BITS))
        begin
            slot_bits_next = 4'(ADDR_BITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_bits_reg  <= 4'(SB_RST);
            clr_cnt_reg    <= '0;
            entries_reg    <= '0;
            collisions_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                slot_bits_reg <= slot_bits_next;
            end
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_BITS'(1);
            end
            if (ins_write)
            begin
                entries_reg <= entries_reg + CNT_W'(1);
            end
            if (coll_inc)
            begin
                collisions_reg <= collisions_reg + 32'd1;
            end
            done_reg <= probe_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= operation;
            key_reg       <= key_in;
            data_reg      <= data_word[DATA_BITS-1:0];
            step_reg      <= step_m[ADDR_BITS-1:0];
            raw_reg       <= first_m[ADDR_BITS-1:0];
            probe_cnt_reg <= '0;
        end
        else if (cmd.probe && !probe_done)
        begin
            raw_reg       <= raw_next;
            probe_cnt_reg <= cnt_inc;
        end
        if (probe_done)
        begin
            found_reg <= res_found;
            slot_reg  <= res_found ? 10'(cur_addr) : 10'd0;
            dout_reg  <= 64'(res_data);
            err_reg   <= res_err;
        end
    end

    assign done            = done_reg;
    assign found           = found_reg;
    assign slot_index      = slot_reg;
    assign data_out        = dout_reg;
    assign probe_error     = err_reg;
    assign entry_count     = 11'(entries_reg);
    assign collision_count = collisions_reg;

endmodule

// ===== design/double_hash_table_engine.sv =====
// ----------------------------------------------------------------------------
// double_hash_table_engine
// Open-addressing hash table with double hashing: insert and lookup of a
// two-half key, probe path home slot plus multiples of the key stride.
// ----------------------------------------------------------------------------
// Usage: after reset the key memory is swept to empty, one slot a cycle, and
// busy stays high until the sweep is through, before the first item is taken.
// An item is taken when start is high and busy is low. It then walks 1 up to
// 2**slot_bits probes: the key memory has a single read port and is checked
// one slot per cycle. The result shows for exactly one cycle with done high,
// in the same cycle that busy drops, and the receiver cannot stall it; a new
// item may be started in that same cycle. entry_count and collision_count
// hold the totals after the item. slot_bits is written by the user through
// the cfg channel (always ready) only while idle; the block does not enforce it.
module double_hash_table_engine
    import dhte_pkg::*;
#(
    parameter int ADDR_BITS = 10,
    parameter int KEY_BITS  = 32,
    parameter int DATA_BITS = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic         operation,
    input  logic [31:0]  key_first,
    input  logic [31:0]  key_step,
    input  logic [63:0]  data_word,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_data,
    output logic         done,
    output logic         found,
    output logic [9:0]   slot_index,
    output logic [63:0]  data_out,
    output logic         probe_error,
    output logic [10:0]  entry_count,
    output logic [31:0]  collision_count
);

    ctl_cmd_t    cmd;
    ctl_status_t status;

    assign cfg_ready = 1'b1;

    dhte_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    dhte_datapath #(
        .ADDR_BITS (ADDR_BITS),
        .KEY_BITS  (KEY_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_valid & cfg_ready),
        .cfg_data        (cfg_data),
        .operation       (operation),
        .key_first       (key_first),
        .key_step        (key_step),
        .data_word       (data_word),
        .done            (done),
        .found           (found),
        .slot_index      (slot_index),
        .data_out        (data_out),
        .probe_error     (probe_error),
        .entry_count     (entry_count),
        .collision_count (collision_count)
    );

endmodule

// ===== sim/double_hash_table_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_hash_table_engine_tb
// Self-checking bench for the double-hashing table engine. A queue-fed driver
// sends inserts and lookups through the start/busy command port. At each
// transfer a local copy of the table works out the expected result. The
// monitor compares every done strobe, field by field, against the oldest
// expected result. Directed items come first: empty and full tables,
// all-zero keys, duplicates, zero and short strides. Random phases follow
// under several slot_bits settings, out-of-range values included.
// ----------------------------------------------------------------------------
module double_hash_table_engine_tb;
    import dhte_pkg::*;

    localparam int          ADDR_W          = 10;
    localparam int          ITEMS_PER_PHASE = 62;
    // watchdog room for every item at a full 2**10 probe walk plus gaps
    localparam int unsigned LIMIT_CYCLES    = 4_000_000;

    typedef struct packed {
        logic        op;
        logic [31:0] key_first;
        logic [31:0] key_step;
        logic [63:0] data_word;
    } hash_item_t;

    typedef struct packed {
        logic        found;
        logic [9:0]  slot_index;
        logic [63:0] data_out;
        logic        probe_error;
        logic [10:0] entry_count;
        logic [31:0] collision_count;
    } hash_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        operation = OP_INSERT;
    logic [31:0] key_first = '0;
    logic [31:0] key_step = '0;
    logic [63:0] data_word = '0;
    logic        cfg_valid = 1'b0;
    logic [3:0]  cfg_data = '0;
    logic        busy;
    logic        cfg_ready;
    logic        done;
    logic        found;
    logic [9:0]  slot_index;
    logic [63:0] data_out;
    logic        probe_error;
    logic [10:0] entry_count;
    logic [31:0] collision_count;

    // local copy of the table
    logic [63:0] slot_keys [1 << ADDR_W];
    logic [63:0] slot_payloads [1 << ADDR_W];
    logic [10:0] entry_total = '0;
    logic [31:0] collision_total = '0;
    int unsigned model_slot_bits = ADDR_W;

    hash_item_t   items_to_send [$];
    hash_result_t answers_due [$];
    logic [63:0]  stored_keys [$];
    hash_result_t answer;
    bit           steady_feed = 1'b0;
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count = 0;
    logic [3:0]   phase_bits [12] = '{4'd1, 4'd10, 4'd3, 4'd15, 4'd2, 4'd6,
                                      4'd0, 4'd4, 4'd8, 4'd9, 4'd5, 4'd7};

    double_hash_table_engine dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .key_first       (key_first),
        .key_step        (key_step),
        .data_word       (data_word),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .done            (done),
        .found           (found),
        .slot_index      (slot_index),
        .data_out        (data_out),
        .probe_error     (probe_error),
        .entry_count     (entry_count),
        .collision_count (collision_count)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Walks the probe path of one item, updates the table copy and
    // returns the result the engine must report.
    function automatic hash_result_t probe_and_update(hash_item_t it);
        hash_result_t r;
        logic [63:0]  key;
        logic [31:0]  mask;
        logic [31:0]  idx;
        logic [31:0]  s;
        logic [31:0]  limit;
        logic [31:0]  home;
        r = '0;
        key = {it.key_first, it.key_step};
        mask = (32'd1 << model_slot_bits) - 32'd1;
        limit = mask + 32'd1;
        home = it.key_first & mask;
        if (it.op == OP_INSERT)
        begin
            if (key != 64'd0)
            begin
                if (slot_keys[home[9:0]] != 64'd0 && collision_total != '1)
                    collision_total++;
                r.probe_error = 1'b1;
                for (idx = 0; idx < limit; idx++)
                begin
                    s = (it.key_first + idx * it.key_step) & mask;
                    if (slot_keys[s[9:0]] == 64'd0)
                    begin
                        slot_keys[s[9:0]] = key;
                        slot_payloads[s[9:0]] = it.data_word;
                        entry_total++;
                        r.found = 1'b1;
                        r.slot_index = s[9:0];
                        r.data_out = it.data_word;
                        r.probe_error = 1'b0;
                        break;
                    end
                end
            end
        end
        else
        begin
            r.probe_error = 1'b1;
            for (idx = 0; idx < limit; idx++)
            begin
                s = (it.key_first + idx * it.key_step) & mask;
                if (slot_keys[s[9:0]] == 64'd0)
                begin
                    r.probe_error = 1'b0;
                    break;
                end
                if (slot_keys[s[9:0]] == key)
                begin
                    r.found = 1'b1;
                    r.slot_index = s[9:0];
                    r.data_out = slot_payloads[s[9:0]];
                    r.probe_error = 1'b0;
                    break;
                end
            end
        end
        r.entry_count = entry_total;
        r.collision_count = collision_total;
        return r;
    endfunction

    // Mostly well-formed traffic: lookups of stored keys, home-slot clashes,
    // duplicates, with some cycling strides and all-zero keys mixed in.
    function automatic hash_item_t random_item();
        hash_item_t  it;
        int unsigned pick;
        int unsigned reuse;
        logic [63:0] old_key;
        it.op = ($urandom_range(1) == 0) ? OP_INSERT : OP_LOOKUP;
        it.key_first = $urandom;
        it.key_step = $urandom;
        it.data_word = {$urandom, $urandom};
        pick = $urandom_range(99);
        reuse = (it.op == OP_LOOKUP) ? 55 : 10;
        old_key = (stored_keys.size() != 0) ?
                  stored_keys[$urandom_range(stored_keys.size() - 1)] : 64'd0;
        if (old_key != 64'd0 && pick < reuse)
            {it.key_first, it.key_step} = old_key;
        else if (old_key != 64'd0 && pick < 75)
            it.key_first = old_key[63:32];
        else if (pick < 82)
            it.key_step = 32'd1 << $urandom_range(ADDR_W - 1);
        else if (pick < 85)
            it.key_step = '0;
        else if (pick < 88)
        begin
            it.key_first = '0;
            it.key_step = '0;
        end
        return it;
    endfunction

    task automatic queue_item(input logic op, input logic [31:0] kf,
                              input logic [31:0] ks, input logic [63:0] d);
        hash_item_t it;
        it = '{op, kf, ks, d};
        items_to_send.push_back(it);
        if (op == OP_INSERT && {kf, ks} != 64'd0)
            stored_keys.push_back({kf, ks});
    endtask

    task automatic write_slot_bits(input logic [3:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_data <= 4'($urandom);
        if (v == 4'd0)
            model_slot_bits = 1;
        else if (v > ADDR_W)
            model_slot_bits = ADDR_W;
        else
            model_slot_bits = v;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (items_to_send.size() != 0 || answers_due.size() != 0 || busy)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // driver: an item transfers when start is high and busy is low
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                answers_due.push_back(probe_and_update(items_to_send[0]));
                void'(items_to_send.pop_front());
            end
            if (items_to_send.size() != 0 && (steady_feed || $urandom_range(99) >= 38))
            begin
                start <= 1'b1;
                operation <= items_to_send[0].op;
                key_first <= items_to_send[0].key_first;
                key_step <= items_to_send[0].key_step;
                data_word <= items_to_send[0].data_word;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor: done marks a one-cycle result that cannot be held off
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (answers_due.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with nothing expected, expected none, actual slot %0h",
                         $time, slot_index);
            end
            else
            begin
                answer = answers_due.pop_front();
                check_field("found", answer.found, found);
                check_field("slot_index", answer.slot_index, slot_index);
                check_field("data_out", answer.data_out, data_out);
                check_field("probe_error", answer.probe_error, probe_error);
                check_field("entry_count", answer.entry_count, entry_count);
                check_field("collision_count", answer.collision_count, collision_count);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("[double_hash_table_engine] ERROR");
            $finish;
        end
    end

    initial
    begin
        hash_item_t it;
        for (int i = 0; i < (1 << ADDR_W); i++)
        begin
            slot_keys[i] = '0;
            slot_payloads[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        // key memory sweep after reset
        @(negedge clk);
        while (busy)
            @(negedge clk);

        // reset setting: 1024 slots
        queue_item(OP_LOOKUP, 32'h1234_5678, 32'h0000_0009, 64'd0);
        queue_item(OP_INSERT, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_item(OP_LOOKUP, 32'h0, 32'h0, 64'd0);
        queue_item(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0);
        // duplicate goes one stride further and counts a collision
        queue_item(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h5555_5555_5555_5555);
        queue_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0);
        queue_item(OP_INSERT, 32'h0, 32'h1, 64'd0);
        // zero stride on an occupied home slot walks the limit
        queue_item(OP_INSERT, 32'h400, 32'h0, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_item(OP_LOOKUP, 32'h400, 32'h0, 64'd0);
        queue_item(OP_INSERT, 32'hC00, 32'h401, 64'h0123_4567_89AB_CDEF);
        queue_item(OP_LOOKUP, 32'hC00, 32'h401, 64'd0);
        queue_item(OP_LOOKUP, 32'h800, 32'h1, 64'd0);
        wait_idle();

        // zero acts as one: two slots, both taken
        write_slot_bits(4'd0);
        queue_item(OP_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 64'hFEDC_BA98_7654_3210);
        queue_item(OP_LOOKUP, 32'h0, 32'h1, 64'd0);
        queue_item(OP_LOOKUP, 32'h0, 32'h0, 64'd0);
        queue_item(OP_LOOKUP, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 64'd0);
        wait_idle();

        // above range acts as ADDR_BITS; top slots are visible again
        write_slot_bits(4'd15);
        queue_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0);
        queue_item(OP_LOOKUP, 32'hC00, 32'h401, 64'd0);
        wait_idle();

        foreach (phase_bits[p])
        begin
            write_slot_bits(phase_bits[p]);
            steady_feed = (p == 3);
            repeat (ITEMS_PER_PHASE)
            begin
                it = random_item();
                queue_item(it.op, it.key_first, it.key_step, it.data_word);
            end
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("[double_hash_table_engine] OK");
        else
            $display("[double_hash_table_engine] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/dhte_pkg.sv
design/dhte_ctrl.sv
design/dhte_datapath.sv
design/double_hash_table_engine.sv
sim/double_hash_table_engine_tb.sv
